FILE: rtl/signed_int_to_decimal_ascii_assert.svh
// Assertion macros used by the checker file of the decimal text block.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SIDA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SIDA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/sida_pkg.sv
// Shared constants and types of the signed integer to decimal text block.
package sida_pkg;

	localparam int VALUE_WIDTH = 32;
	// Decimal digits needed for a magnitude up to 2^VALUE_WIDTH - 1.
	localparam int NDIG = ((VALUE_WIDTH * 1233) >> 12) + 1;
	localparam int BCD_W = 4 * NDIG;
	localparam int CNT_W = $clog2(VALUE_WIDTH);
	localparam int DIG_W = $clog2(NDIG);

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [7:0] CHAR_ZERO = 8'd48;
	localparam logic [7:0] CHAR_MINUS = 8'd45;
	localparam logic [7:0] CHAR_NINE = 8'd57;

	typedef struct packed {
		logic neg;
		logic [VALUE_WIDTH-1:0] mag;
	} item_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CONV = 4'b0010,
		ST_SIGN = 4'b0100,
		ST_EMIT = 4'b1000
	} back_state_t;

endpackage

FILE: rtl/sida_fifo.sv
// Small request queue between the front and back parts.
module sida_fifo (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  sida_pkg::item_t push_item,
	input  logic pop,
	output sida_pkg::item_t pop_item,
	output logic full,
	output logic empty
);

	sida_pkg::item_t slot_q [sida_pkg::QDEPTH];
	logic [sida_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [sida_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [sida_pkg::QCNT_W-1:0] count_q;

	assign full = (count_q == sida_pkg::QCNT_W'(sida_pkg::QDEPTH));
	assign empty = (count_q == '0);
	assign pop_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == sida_pkg::QPTR_W'(sida_pkg::QDEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == sida_pkg::QPTR_W'(sida_pkg::QDEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/sida_front.sv
// Front part: accept a request, split it into sign and unsigned magnitude.
module sida_front (
	input  logic start,
	input  logic [sida_pkg::VALUE_WIDTH-1:0] value,
	input  logic q_full,
	output logic busy,
	output logic push,
	output sida_pkg::item_t push_item
);

	logic neg;

	assign busy = q_full;
	assign push = start && !q_full;
	assign neg = value[sida_pkg::VALUE_WIDTH-1];

	// Negate modulo 2^VALUE_WIDTH so the most negative value keeps its magnitude.
	always_comb begin
		push_item.neg = neg;
		push_item.mag = neg ? (~value + 1'b1) : value;
	end

endmodule

FILE: rtl/sida_back.sv
// Back part: shift-add-3 conversion to BCD, then character emission.
module sida_back (
	input  logic clk,
	input  logic arst_n,
	input  logic q_empty,
	input  sida_pkg::item_t pop_item,
	output logic pop,
	output logic [7:0] character,
	output logic last,
	output logic strobe
);

	sida_pkg::back_state_t state_q;
	logic [sida_pkg::VALUE_WIDTH-1:0] bin_q;
	logic [sida_pkg::BCD_W-1:0] bcd_q;
	logic neg_q;
	logic started_q;
	logic [sida_pkg::CNT_W-1:0] cnt_q;
	logic [sida_pkg::DIG_W-1:0] dig_q;
	logic [7:0] character_q;
	logic last_q;
	logic strobe_q;

	logic [sida_pkg::BCD_W-1:0] bcd_adj;
	logic [sida_pkg::BCD_W+sida_pkg::VALUE_WIDTH-1:0] shifted;
	logic [3:0] top_digit;
	logic is_last_digit;
	logic emit;

	assign pop = (state_q == sida_pkg::ST_IDLE) && !q_empty;

	// Add 3 to every digit of 5 or more before the shift.
	always_comb begin
		for (int i = 0; i < sida_pkg::NDIG; i++) begin
			bcd_adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ?
				bcd_q[i*4 +: 4] + 4'd3 : bcd_q[i*4 +: 4];
		end
	end

	assign shifted = {bcd_adj, bin_q} << 1;
	assign top_digit = bcd_q[sida_pkg::BCD_W-1 -: 4];
	assign is_last_digit = (dig_q == sida_pkg::DIG_W'(sida_pkg::NDIG - 1));
	// Drop leading zeros, but always show the units digit.
	assign emit = started_q || (top_digit != 4'd0) || is_last_digit;

	always_ff @(posedge clk) begin
		case (state_q)
			sida_pkg::ST_IDLE: begin
				bin_q <= pop_item.mag;
				neg_q <= pop_item.neg;
				bcd_q <= '0;
			end
			sida_pkg::ST_CONV: begin
				bcd_q <= shifted[sida_pkg::BCD_W+sida_pkg::VALUE_WIDTH-1 -: sida_pkg::BCD_W];
				bin_q <= shifted[sida_pkg::VALUE_WIDTH-1:0];
			end
			sida_pkg::ST_SIGN: begin
				character_q <= sida_pkg::CHAR_MINUS;
				last_q <= 1'b0;
			end
			sida_pkg::ST_EMIT: begin
				bcd_q <= bcd_q << 4;
				character_q <= sida_pkg::CHAR_ZERO + {4'd0, top_digit};
				last_q <= is_last_digit;
			end
			default: begin
				bcd_q <= bcd_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sida_pkg::ST_IDLE;
			cnt_q <= '0;
			dig_q <= '0;
			started_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				sida_pkg::ST_IDLE: begin
					cnt_q <= '0;
					if (!q_empty) begin
						state_q <= sida_pkg::ST_CONV;
					end
				end
				sida_pkg::ST_CONV: begin
					cnt_q <= cnt_q + 1'b1;
					dig_q <= '0;
					started_q <= 1'b0;
					if (cnt_q == sida_pkg::CNT_W'(sida_pkg::VALUE_WIDTH - 1)) begin
						state_q <= neg_q ? sida_pkg::ST_SIGN : sida_pkg::ST_EMIT;
					end
				end
				sida_pkg::ST_SIGN: begin
					strobe_q <= 1'b1;
					state_q <= sida_pkg::ST_EMIT;
				end
				sida_pkg::ST_EMIT: begin
					strobe_q <= emit;
					started_q <= started_q || (top_digit != 4'd0);
					dig_q <= dig_q + 1'b1;
					if (is_last_digit) begin
						state_q <= sida_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= sida_pkg::ST_IDLE;
				end
			endcase
		end
	end

	assign character = character_q;
	assign last = last_q;
	assign strobe = strobe_q;

endmodule

FILE: rtl/signed_int_to_decimal_ascii.sv
// Top level: signed 32-bit integer to decimal ASCII text, one character per strobe.
// Path of a request with the back part idle: queue hand-off, 32 conversion steps, a sign step
// for a negative value, then the ten-digit scan that ends with the last character on strobe.
// The back part converts one number at a time with a serial shift-add-3 loop (one bit per cycle)
// and a ten-digit scan, while the queue takes new requests meanwhile; no output stall.
// Reset: arst_n clears the queue and the back sequencer asynchronously; strobe is low after it.
module signed_int_to_decimal_ascii (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [sida_pkg::VALUE_WIDTH-1:0] value,
	output logic strobe,
	output logic [7:0] character,
	output logic last
);

	// Front to queue: a classified request (sign flag plus unsigned magnitude).
	logic push;
	sida_pkg::item_t push_item;
	// Queue to back: the oldest waiting request.
	sida_pkg::item_t pop_item;
	logic pop;
	logic q_full;
	logic q_empty;

	// Take a request whenever the queue has room, even while the back part
	// is still converting or emitting an earlier number.
	sida_front u_front (
		.start(start),
		.value(value),
		.q_full(q_full),
		.busy(busy),
		.push(push),
		.push_item(push_item)
	);

	// Two-entry queue decouples request acceptance from conversion.
	sida_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.pop(pop),
		.pop_item(pop_item),
		.full(q_full),
		.empty(q_empty)
	);

	// Convert one magnitude to BCD bit by bit, then scan the digits from the
	// top, dropping leading zeros and marking the units digit as last.
	sida_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.pop_item(pop_item),
		.pop(pop),
		.character(character),
		.last(last),
		.strobe(strobe)
	);

endmodule

FILE: rtl/sida_checker.sv
// Port-level checker for the decimal text block, bound to the top level.
`include "signed_int_to_decimal_ascii_assert.svh"

module sida_checker (
	input logic clk,
	input logic arst_n,
	input logic strobe,
	input logic [7:0] character,
	input logic last
);

	logic is_minus;
	logic is_digit;

	assign is_minus = (character == sida_pkg::CHAR_MINUS);
	assign is_digit = (character >= sida_pkg::CHAR_ZERO) && (character <= sida_pkg::CHAR_NINE);

	`SIDA_ASSERT_SAME(a_char_legal, clk, arst_n, strobe, is_minus || is_digit, "illegal character")
	`SIDA_ASSERT_SAME(a_minus_not_last, clk, arst_n, strobe && is_minus, !last, "minus flagged last")
	`SIDA_ASSERT_NEXT(a_gap_after_last, clk, arst_n, strobe && last, !strobe, "char right after last")
	`SIDA_ASSERT_NEXT(a_digit_run, clk, arst_n, strobe && is_digit && !last, strobe, "gap in digits")

endmodule

bind signed_int_to_decimal_ascii sida_checker u_sida_checker (.*);

FILE: test/signed_int_to_decimal_ascii_test.sv
// Testbench for signed_int_to_decimal_ascii: predicts each character of the text and checks it.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_test;

	localparam int W = sida_pkg::VALUE_WIDTH;
	localparam int NUM_RANDOM = 228;
	// Requests near the end go out back to back, with no idle bursts.
	localparam int CALM_TAIL = 40;
	// Watch for stray characters after the expected text has drained.
	localparam int SETTLE_CYCLES = 60;

	typedef struct {
		logic [7:0] character;
		logic last;
	} text_char_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [W-1:0] value;
	logic strobe;
	logic [7:0] character;
	logic last;

	logic [W-1:0] pending_values[$];
	text_char_t expected_text[$];
	int num_directed;
	int num_total;
	int sent_cnt;
	int gap_left;
	int failures;
	logic req_taken;

	signed_int_to_decimal_ascii DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.value(value),
		.strobe(strobe),
		.character(character),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Work out the characters that one request must produce and queue them in order.
	task automatic predict_text(input logic [W-1:0] v);
		logic neg;
		logic [W-1:0] mag;
		int digit_buf[20];
		int nd;
		text_char_t c;
		neg = v[W-1];
		// Take the magnitude as unsigned, so the most negative value stays exact.
		mag = neg ? (~v + 1'b1) : v;
		nd = 0;
		if (mag == '0) begin
			c.character = sida_pkg::CHAR_ZERO;
			c.last = 1'b1;
			expected_text.push_back(c);
		end else begin
			while (mag != '0) begin
				digit_buf[nd] = int'(mag % 10);
				mag = mag / 10;
				nd++;
			end
			if (neg) begin
				c.character = sida_pkg::CHAR_MINUS;
				c.last = 1'b0;
				expected_text.push_back(c);
			end
			while (nd > 0) begin
				nd--;
				c.character = sida_pkg::CHAR_ZERO + 8'(digit_buf[nd]);
				c.last = (nd == 0);
				expected_text.push_back(c);
			end
		end
	endtask

	// Pick a value: mostly a random digit count with a random sign, sometimes raw bits or an edge.
	function automatic logic [W-1:0] random_value();
		longint lo;
		longint hi;
		longint mag;
		int ndig;
		case ($urandom_range(0, 7))
			0, 1: return W'($urandom);
			2: begin
				case ($urandom_range(0, 3))
					0: return '0;
					1: return {1'b1, {(W-1){1'b0}}};
					2: return {1'b0, {(W-1){1'b1}}};
					default: return '1;
				endcase
			end
			default: begin
				ndig = $urandom_range(1, 10);
				lo = 1;
				repeat (ndig - 1) lo = lo * 10;
				hi = lo * 10 - 1;
				if (ndig == 1) lo = 0;
				if (hi > 64'sd2147483647) hi = 64'sd2147483647;
				mag = lo + longint'($urandom_range(0, int'(hi - lo)));
				if ($urandom_range(0, 1)) mag = -mag;
				return W'(mag);
			end
		endcase
	endfunction

	// Hold off before a request here until every queued character has come out.
	function automatic bit drain_point(input int n);
		return (n == num_directed) || (n == num_directed + NUM_RANDOM / 2);
	endfunction

	// Driver: change inputs on the falling edge, advance the queue after each accepted request.
	always @(negedge clk) begin
		logic go;
		go = 1'b0;
		if (arst_n) begin
			if (req_taken) begin
				void'(pending_values.pop_front());
				sent_cnt++;
			end
			if (gap_left != 0) begin
				gap_left--;
			end else if (pending_values.size() != 0) begin
				if (drain_point(sent_cnt) && (expected_text.size() != 0 || busy)) begin
					// Hold the request until the text of the previous ones is out.
					go = 1'b0;
				end else if (sent_cnt < num_total - CALM_TAIL && $urandom_range(0, 23) == 0) begin
					// Drop start for a burst, so requests land on every phase of the work.
					gap_left = $urandom_range(0, 18);
				end else begin
					go = 1'b1;
				end
			end
		end
		start <= go;
		if (go) begin
			value <= pending_values[0];
		end else begin
			// Drive noise on value while no request is up; the block must ignore it.
			value <= W'($urandom);
		end
	end

	// Monitor: sample on the rising edge, predict accepted requests, check each strobe.
	always @(posedge clk) begin
		text_char_t want;
		req_taken <= arst_n && start && !busy;
		if (arst_n) begin
			if (strobe) begin
				if (expected_text.size() == 0) begin
					$error("unexpected character %0d (last %0b) with nothing pending",
						character, last);
					failures++;
				end else begin
					want = expected_text.pop_front();
					if (character !== want.character) begin
						$error("character mismatch: expected %0d, actual %0d",
							want.character, character);
						failures++;
					end
					if (last !== want.last) begin
						$error("last mismatch: expected %0b, actual %0b", want.last, last);
						failures++;
					end
				end
			end
			if (start && !busy) predict_text(value);
		end
	end

	initial begin
		logic [W-1:0] directed[] = '{
			32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
			-32'sd9, 32'd7, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
			32'd1000000000, 32'd999999999, -32'sd999999999, 32'd123456789,
			-32'sd123456789, 32'h5555_5555, 32'hAAAA_AAAA, -32'sd1000000000,
			32'd4294967295
		};
		arst_n = 1'b0;
		start = 1'b0;
		value = '0;
		req_taken = 1'b0;
		sent_cnt = 0;
		gap_left = 0;
		failures = 0;

		// Directed requests: sign, zero, digit-count edges and the extremes of the field.
		foreach (directed[i]) pending_values.push_back(directed[i]);
		num_directed = directed.size();
		for (int i = 0; i < NUM_RANDOM; i++) pending_values.push_back(random_value());
		num_total = pending_values.size();

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// Wait for every request to be taken, then for the text to drain.
		while (pending_values.size() != 0 || start) @(posedge clk);
		while (expected_text.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (failures == 0 && expected_text.size() == 0) begin
			$display("signed_int_to_decimal_ascii verification clean");
		end else begin
			$display("signed_int_to_decimal_ascii verification failed");
		end
		$finish;
	end

	// Stop a hung run; the slowest correct run is far below this.
	initial begin
		#2ms;
		$display("signed_int_to_decimal_ascii verification failed");
		$finish;
	end

endmodule
